@@ sv/sha256_stream_hasher_top_macros.svh @@
// Assertion macros shared by the SHA-256 stream hasher modules.
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define SHS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shs: same-cycle check failed");

// Next-cycle implication, checked while reset is released.
`define SHS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shs: next-cycle check failed");

`endif

@@ sv/shs_pkg.sv @@
// Package with the types, constants and round functions of the SHA-256 hasher.
package shs_pkg;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST = 3'd7;
    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD_ZERO,
        S_PAD_LEN,
        S_LOAD,
        S_ROUND,
        S_FOLD,
        S_EMIT
    } shs_state_t;

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } shs_byte_sel_t;

    typedef struct packed {
        logic          load_byte;
        shs_byte_sel_t byte_sel;
        logic [2:0]    len_sel;
        logic          count_len;
        logic          load_wv;
        logic          round;
        logic [5:0]    rnd;
        logic          fold;
        logic          init;
        logic [2:0]    word_sel;
    } shs_cmd_t;

    function automatic logic [31:0] iv(input logic [2:0] i);
        logic [31:0] v;
        case (i)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

@@ sv/sha256_stream_hasher_top.sv @@
// Top level of the SHA-256 stream hasher: controller plus datapath.
//
//  channel | signals                                  | role
//  --------+------------------------------------------+---------------------------------
//  in      | in_valid, in_stall, action, data_byte    | append a byte or finish message
//  out     | out_valid, out_stall, digest_word,       | eight digest words per finish,
//          | word_index, last_word                    | last_word on the eighth
//
// An append transaction that fills a block adds a compression (one load, 64 rounds
// of the shared round unit, one fold). A finish transaction shifts padding in byte
// by byte up to offset 64, runs one or two compressions, then offers the eight
// digest words, one per accepted output.
// Reset (rst_n low, asynchronous) loads the initial chaining values and clears counts.
// Input is stalled while padding, compressing or emitting; output stalls hold the
// current word and index stable and simply extend the emit phase.
module sha256_stream_hasher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import shs_pkg::*;

    // The controller sequences every byte shift, round and fold through this command.
    shs_cmd_t cmd;

    shs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .word_index (word_index),
        .last_word  (last_word),
        .cmd        (cmd)
    );

    // The datapath holds the block window, working variables, length and chaining state.
    shs_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .digest_word (digest_word)
    );

endmodule

@@ sv/shs_dpath.sv @@
// Datapath of the SHA-256 hasher: block window, working variables, chaining state.
module shs_dpath (
    input  logic             clk,
    input  logic             rst_n,
    input  shs_pkg::shs_cmd_t cmd,
    input  logic [7:0]       data_byte,
    output logic [31:0]      digest_word
);
    import shs_pkg::*;

    // The block window doubles as the message schedule; word 0 sits at the top.
    logic [511:0] win_reg, win_next;
    logic [31:0]  h_reg [8];
    logic [31:0]  wv_reg [8];
    logic [63:0]  len_reg;
    logic [7:0]   byte_in;
    logic [31:0]  w0, w1, w9, w14, w_new, t1, t2, ch, maj;

    assign w0  = win_reg[511:480];
    assign w1  = win_reg[479:448];
    assign w9  = win_reg[223:192];
    assign w14 = win_reg[63:32];
    assign w_new = small_s1(w14) + w9 + small_s0(w1) + w0;

    assign ch  = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
    assign maj = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]);
    assign t1  = wv_reg[7] + big_s1(wv_reg[4]) + ch + round_k(cmd.rnd) + w0;
    assign t2  = big_s0(wv_reg[0]) + maj;

    always_comb
    begin
        case (cmd.byte_sel)
            SEL_DATA: byte_in = data_byte;
            SEL_MARK: byte_in = PAD_MARK;
            SEL_ZERO: byte_in = 8'h00;
            SEL_LEN:  byte_in = len_reg[8 * (7 - cmd.len_sel) +: 8];
            default:  byte_in = 8'h00;
        endcase
        win_next = win_reg;
        if (cmd.load_byte)
        begin
            win_next = {win_reg[503:0], byte_in};
        end
        else if (cmd.round)
        begin
            win_next = {win_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        if (cmd.load_wv)
        begin
            for (int i = 0; i < 8; i++)
            begin
                wv_reg[i] <= h_reg[i];
            end
        end
        else if (cmd.round)
        begin
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= iv(3'(i));
            end
            len_reg <= '0;
        end
        else
        begin
            if (cmd.init)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= iv(3'(i));
                end
                len_reg <= '0;
            end
            else
            begin
                if (cmd.fold)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + wv_reg[i];
                    end
                end
                if (cmd.count_len)
                begin
                    len_reg <= len_reg + 64'd8;
                end
            end
        end
    end

    assign digest_word = h_reg[cmd.word_sel];

endmodule

@@ sv/shs_ctrl.sv @@
// Controller state machine of the SHA-256 hasher: byte intake, padding, rounds, output.
`include "sha256_stream_hasher_top_macros.svh"
module shs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        word_index,
    output logic              last_word,
    output shs_pkg::shs_cmd_t cmd
);
    import shs_pkg::*;

    shs_state_t state_reg, state_next;
    logic [5:0] fill_reg, fill_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       padding_reg, padding_next;
    logic       final_reg, final_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            rnd_reg     <= '0;
            idx_reg     <= '0;
            padding_reg <= 1'b0;
            final_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rnd_reg     <= rnd_next;
            idx_reg     <= idx_next;
            padding_reg <= padding_next;
            final_reg   <= final_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        rnd_next     = rnd_reg;
        idx_next     = idx_reg;
        padding_next = padding_reg;
        final_next   = final_reg;
        cmd          = '0;
        cmd.byte_sel = SEL_DATA;
        cmd.rnd      = rnd_reg;
        cmd.len_sel  = fill_reg[2:0];
        cmd.word_sel = idx_reg;
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_byte = 1'b1;
                    fill_next = fill_reg + 6'd1;
                    if (action == ACT_FINISH)
                    begin
                        cmd.byte_sel = SEL_MARK;
                        padding_next = 1'b1;
                        state_next = (fill_reg == FILL_LAST) ? S_LOAD : S_PAD_ZERO;
                    end
                    else
                    begin
                        cmd.count_len = 1'b1;
                        if (fill_reg == FILL_LAST)
                        begin
                            state_next = S_LOAD;
                        end
                    end
                end
            end
            S_PAD_ZERO:
            begin
                if (fill_reg == LEN_START)
                begin
                    state_next = S_PAD_LEN;
                end
                else
                begin
                    cmd.load_byte = 1'b1;
                    cmd.byte_sel = SEL_ZERO;
                    fill_next = fill_reg + 6'd1;
                    if (fill_reg == FILL_LAST)
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_PAD_LEN:
            begin
                cmd.load_byte = 1'b1;
                cmd.byte_sel = SEL_LEN;
                fill_next = fill_reg + 6'd1;
                if (fill_reg == FILL_LAST)
                begin
                    final_next = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_wv = 1'b1;
                rnd_next = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == ROUND_LAST)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.fold = 1'b1;
                idx_next = '0;
                if (final_reg)
                begin
                    state_next = S_EMIT;
                end
                else if (padding_reg)
                begin
                    state_next = S_PAD_ZERO;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == WORD_LAST)
                    begin
                        cmd.init = 1'b1;
                        padding_next = 1'b0;
                        final_next = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign word_index = idx_reg;
    assign last_word  = (idx_reg == WORD_LAST);

    `SHS_ASSERT_NOW(a_no_intake_while_emit, state_reg == S_EMIT, in_stall)
    `SHS_ASSERT_NEXT(a_rounds_end_in_fold, state_reg == S_ROUND && rnd_reg == ROUND_LAST,
        state_reg == S_FOLD)
    `SHS_ASSERT_NOW(a_len_bytes_at_tail, state_reg == S_PAD_LEN, fill_reg >= LEN_START)
    `SHS_ASSERT_NEXT(a_last_word_frees_block, out_valid && !out_stall && last_word,
        state_reg == S_IDLE && fill_reg == 6'd0 && !padding_reg)

endmodule
